FILE: rtl/core/pqbm_pkg.sv
package pqbm_pkg;

	localparam int NUM_QUEUES_DEF = 16;
	localparam int NUM_SLOTS_DEF  = 64;

	localparam int KIND_W   = 2;
	localparam int QID_W    = 4;
	localparam int TAG_W    = 16;
	localparam int LEN_W    = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int BYTES_W  = 24;

	localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

	localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOSLOT  = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SLOT
	} state_t;

	typedef struct packed {
		logic accept;
		logic slot_rd;
		logic finish;
	} pqbm_cmd_t;

	typedef struct packed {
		logic enq;
		logic out_free;
	} pqbm_stat_t;

endpackage

FILE: rtl/core/pqbm_ctrl.sv
module pqbm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pqbm_pkg::pqbm_stat_t  stat,
	output pqbm_pkg::pqbm_cmd_t   cmd
);
	import pqbm_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_FETCH;
				end
			end
			S_FETCH: begin
				if (!stat.enq) begin
					state_nxt = S_SLOT;
				end else if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_SLOT: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.accept  = 1'b0;
		cmd.slot_rd = 1'b0;
		cmd.finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			S_FETCH: begin
				cmd.slot_rd = !stat.enq;
				cmd.finish  = stat.enq && stat.out_free;
			end
			S_SLOT: begin
				cmd.finish = stat.out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

FILE: rtl/core/pqbm_dp.sv
module pqbm_dp #(
	parameter int NUM_QUEUES = pqbm_pkg::NUM_QUEUES_DEF,
	parameter int NUM_SLOTS  = pqbm_pkg::NUM_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pqbm_pkg::pqbm_cmd_t               cmd,
	output pqbm_pkg::pqbm_stat_t              stat,
	input  logic [pqbm_pkg::BYTES_W-1:0]      capacity,
	input  logic [pqbm_pkg::KIND_W-1:0]       kind,
	input  logic [pqbm_pkg::QID_W-1:0]        queue_id,
	input  logic [pqbm_pkg::TAG_W-1:0]        bundle_tag,
	input  logic [pqbm_pkg::LEN_W-1:0]        bundle_bytes,
	input  logic                              priority_front,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [pqbm_pkg::STATUS_W-1:0]     status,
	output logic [pqbm_pkg::TAG_W-1:0]        head_tag,
	output logic [pqbm_pkg::LEN_W-1:0]        head_bytes,
	output logic [pqbm_pkg::COUNT_W-1:0]      queue_count,
	output logic [pqbm_pkg::COUNT_W-1:0]      total_count,
	output logic [pqbm_pkg::BYTES_W-1:0]      total_bytes
);
	import pqbm_pkg::*;

	localparam int QW    = $clog2(NUM_QUEUES);
	localparam int SW    = $clog2(NUM_SLOTS);
	localparam int CW    = $clog2(NUM_SLOTS + 1);
	localparam int QID_N = 2 ** QID_W;

	typedef struct packed {
		logic [SW-1:0] head;
		logic [SW-1:0] tail;
		logic [CW-1:0] size;
	} qent_t;

	// queue number folded into the configured queue range
	logic [QW-1:0] qmap [QID_N];

	for (genvar gi = 0; gi < QID_N; gi++) begin : g_qmap
		assign qmap[gi] = QW'(gi % NUM_QUEUES);
	end

	logic [KIND_W-1:0] kind_q;
	logic [QW-1:0]     qidx_q;
	logic [TAG_W-1:0]  tag_q;
	logic [LEN_W-1:0]  len_q;
	logic              front_q;

	qent_t         qmem [NUM_QUEUES];
	logic          qvld_q [NUM_QUEUES];
	qent_t         qrd_q;
	logic          qrdv_q;
	qent_t         qent;
	qent_t         qent_nxt;
	logic          qwr;

	logic [SW-1:0] fmem [NUM_SLOTS];
	logic [SW-1:0] frd_q;
	logic [CW-1:0] fc_q;
	logic [CW-1:0] wm_q;
	logic [CW-1:0] fpos;
	logic [CW-1:0] fc_nxt;
	logic [CW-1:0] wm_nxt;
	logic          fwr;
	logic [SW-1:0] slot_new;

	logic [TAG_W-1:0] stag [NUM_SLOTS];
	logic [LEN_W-1:0] slen [NUM_SLOTS];
	logic [SW-1:0]    snext [NUM_SLOTS];
	logic [TAG_W-1:0] rtag_q;
	logic [LEN_W-1:0] rlen_q;
	logic [SW-1:0]    rnext_q;
	logic             swr;
	logic             nwr;
	logic [SW-1:0]    naddr;
	logic [SW-1:0]    ndata;

	logic [CW-1:0]      nb_q;
	logic [CW-1:0]      nb_nxt;
	logic [BYTES_W-1:0] bytes_q;
	logic [BYTES_W-1:0] bytes_nxt;
	logic [BYTES_W:0]   sum;

	logic nospace;
	logic noslot;
	logic empty;
	logic enq;
	logic pop;

	logic [STATUS_W-1:0] st;
	logic [TAG_W-1:0]    htag;
	logic [LEN_W-1:0]    hbytes;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [TAG_W-1:0]    head_tag_q;
	logic [LEN_W-1:0]    head_bytes_q;
	logic [COUNT_W-1:0]  queue_count_q;
	logic [COUNT_W-1:0]  total_count_q;
	logic [BYTES_W-1:0]  total_bytes_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q  <= kind;
			qidx_q  <= qmap[queue_id];
			tag_q   <= bundle_tag;
			len_q   <= bundle_bytes;
			front_q <= priority_front;
		end
	end

	assign enq = (kind_q == KIND_ENQ);
	assign pop = (kind_q == KIND_POP);

	// queue table
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			qrd_q  <= qmem[qmap[queue_id]];
			qrdv_q <= qvld_q[qmap[queue_id]];
		end
		if (qwr) begin
			qmem[qidx_q] <= qent_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				qvld_q[i] <= 1'b0;
			end
		end else if (qwr) begin
			qvld_q[qidx_q] <= 1'b1;
		end
	end

	assign qent = qrdv_q ? qrd_q : '0;

	// free stack, entries below the watermark still hold their own index
	assign fpos     = fc_q - CW'(1);
	assign slot_new = (fpos < wm_q) ? fpos[SW-1:0] : frd_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			frd_q <= fmem[fpos[SW-1:0]];
		end
		if (fwr) begin
			fmem[fc_q[SW-1:0]] <= qent.head;
		end
	end

	// slot store
	always_ff @(posedge clk) begin
		if (cmd.slot_rd) begin
			rtag_q  <= stag[qent.head];
			rlen_q  <= slen[qent.head];
			rnext_q <= snext[qent.head];
		end
		if (swr) begin
			stag[slot_new] <= tag_q;
			slen[slot_new] <= len_q;
		end
		if (nwr) begin
			snext[naddr] <= ndata;
		end
	end

	always_comb begin
		sum      = {1'b0, bytes_q} + (BYTES_W + 1)'(len_q);
		nospace  = (capacity != '0) && (sum > {1'b0, capacity});
		noslot   = (fc_q == '0);
		empty    = (qent.size == '0);
		qent_nxt = qent;
		qwr      = 1'b0;
		swr      = 1'b0;
		nwr      = 1'b0;
		naddr    = slot_new;
		ndata    = qent.head;
		fwr      = 1'b0;
		fc_nxt   = fc_q;
		wm_nxt   = wm_q;
		nb_nxt   = nb_q;
		bytes_nxt = bytes_q;
		st       = ST_OK;
		htag     = '0;
		hbytes   = '0;
		if (enq) begin
			if (nospace) begin
				st = ST_NOSPACE;
			end else if (noslot) begin
				st = ST_NOSLOT;
			end else begin
				qwr    = cmd.finish;
				swr    = cmd.finish;
				fc_nxt = fpos;
				if (fpos < wm_q) begin
					wm_nxt = fpos;
				end
				if (empty) begin
					qent_nxt.head = slot_new;
					qent_nxt.tail = slot_new;
				end else if (front_q) begin
					nwr           = cmd.finish;
					naddr         = slot_new;
					ndata         = qent.head;
					qent_nxt.head = slot_new;
				end else begin
					nwr           = cmd.finish;
					naddr         = qent.tail;
					ndata         = slot_new;
					qent_nxt.tail = slot_new;
				end
				qent_nxt.size = qent.size + CW'(1);
				nb_nxt        = nb_q + CW'(1);
				bytes_nxt     = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
			end
		end else if (empty) begin
			st = ST_EMPTY;
		end else begin
			htag   = rtag_q;
			hbytes = rlen_q;
			if (pop) begin
				qwr = cmd.finish;
				if (qent.size > CW'(1)) begin
					qent_nxt.head = rnext_q;
				end
				qent_nxt.size = qent.size - CW'(1);
				if (fc_q < CW'(NUM_SLOTS)) begin
					fwr    = cmd.finish;
					fc_nxt = fc_q + CW'(1);
				end
				if (nb_q != '0) begin
					nb_nxt = nb_q - CW'(1);
				end
				bytes_nxt = (bytes_q >= BYTES_W'(rlen_q)) ? bytes_q - BYTES_W'(rlen_q) : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q    <= CW'(NUM_SLOTS);
			wm_q    <= CW'(NUM_SLOTS);
			nb_q    <= '0;
			bytes_q <= '0;
		end else if (cmd.finish) begin
			fc_q    <= fc_nxt;
			wm_q    <= wm_nxt;
			nb_q    <= nb_nxt;
			bytes_q <= bytes_nxt;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q      <= st;
			head_tag_q    <= htag;
			head_bytes_q  <= hbytes;
			queue_count_q <= COUNT_W'(qent_nxt.size);
			total_count_q <= COUNT_W'(nb_nxt);
			total_bytes_q <= bytes_nxt;
		end
	end

	assign stat.enq      = enq;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign head_tag    = head_tag_q;
	assign head_bytes  = head_bytes_q;
	assign queue_count = queue_count_q;
	assign total_count = total_count_q;
	assign total_bytes = total_bytes_q;

endmodule

FILE: rtl/core/per_queue_buffer_manager_unit.sv
// an enqueue is accepted in idle and registers its result in the fetch state; pop
// and peek go on from fetch to the slot state, as the slot store read depends on
// the queue table read; a request is taken only when the sequencer is back in idle
// a stalled result word holds the sequencer until it is taken
// reset clears the sequencer, queue valid bits, counters and byte budget;
// the free stack starts full through a watermark, so no clearing pass is needed
module per_queue_buffer_manager_unit #(
	parameter int NUM_QUEUES = pqbm_pkg::NUM_QUEUES_DEF,
	parameter int NUM_SLOTS  = pqbm_pkg::NUM_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pqbm_pkg::ADDR_W-1:0]       paddr,
	input  logic [pqbm_pkg::DATA_W-1:0]       pwdata,
	output logic [pqbm_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pqbm_pkg::KIND_W-1:0]       kind,
	input  logic [pqbm_pkg::QID_W-1:0]        queue_id,
	input  logic [pqbm_pkg::TAG_W-1:0]        bundle_tag,
	input  logic [pqbm_pkg::LEN_W-1:0]        bundle_bytes,
	input  logic                              priority_front,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pqbm_pkg::STATUS_W-1:0]     status,
	output logic [pqbm_pkg::TAG_W-1:0]        head_tag,
	output logic [pqbm_pkg::LEN_W-1:0]        head_bytes,
	output logic [pqbm_pkg::COUNT_W-1:0]      queue_count,
	output logic [pqbm_pkg::COUNT_W-1:0]      total_count,
	output logic [pqbm_pkg::BYTES_W-1:0]      total_bytes
);
	import pqbm_pkg::*;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(NUM_SLOTS);

	logic [BYTES_W-1:0]   capacity_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	pqbm_cmd_t            cmd;
	pqbm_stat_t           stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (cfg_wr && (reg_idx == REG_CAPACITY)) begin
			capacity_q <= pwdata[BYTES_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_CAPACITY: prdata = DATA_W'(capacity_q);
			default:      prdata = '0;
		endcase
	end

	pqbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pqbm_dp #(
		.NUM_QUEUES (NUM_QUEUES),
		.NUM_SLOTS  (NUM_SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.capacity       (capacity_q),
		.kind           (kind),
		.queue_id       (queue_id),
		.bundle_tag     (bundle_tag),
		.bundle_bytes   (bundle_bytes),
		.priority_front (priority_front),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.status         (status),
		.head_tag       (head_tag),
		.head_bytes     (head_bytes),
		.queue_count    (queue_count),
		.total_count    (total_count),
		.total_bytes    (total_bytes)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word loaded while idle");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_EMPTY)) |-> (queue_count == '0 && head_tag == '0))
		else $error("empty queue result carries data");

	a_noslot_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_NOSLOT)) |-> (total_count == FULL_COUNT))
		else $error("no free slot while store not full");

endmodule
